// ===== rtl/rrss_pkg.sv =====
// Types and constants shared by the round-robin slice scheduler.
// Holds the command and status codes, the ring entry layout and the input and result words.
`default_nettype none

package rrss_pkg;

  localparam int unsigned PID_W    = 8;
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned SLICE_W  = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SLICE_W-1:0] QUANTUM_RESET = 8'd4;
  localparam logic [TIME_W-1:0]  LIMIT_RESET   = 32'd1500;
  localparam logic [PID_W-1:0]   PID_FIRST     = 8'd1;

  typedef enum logic {
    CMD_ADD      = 1'b0,
    CMD_DISPATCH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM = 1'b0,
    CFG_LIMIT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [PID_W-1:0]   pid;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    cmd_e               command;
    logic [BURST_W-1:0] burst_time;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [PID_W-1:0]   process_id;
    logic [SLICE_W-1:0] slice_time;
    logic [TIME_W-1:0]  finish_time;
    logic               retired;
    logic               limit_reached;
  } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/rrss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; used for the scheduler's process ring.
`default_nettype none

module rrss_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/round_robin_slice_scheduler.sv =====
// Round-robin slice scheduler: ring of processes served one quantum per dispatch.
// A result word is registered and shown in the cycle after its input word is accepted.
// One word per cycle unless a result stalls; head entry prefetched from ring RAM with bypass.
// Reset: empty ring, identifiers restart at 1, elapsed time 0, quantum 4, limit 1500.
// Ring RAM contents are not cleared; only counted entries are read.
// Depends on rrss_pkg and rrss_ram.
`default_nettype none

module round_robin_slice_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire rrss_pkg::in_word_t                  in_word_i,
  output logic                                     in_stall_o,
  output logic                                     out_valid_o,
  output rrss_pkg::out_word_t                      out_word_o,
  input  wire logic                                out_stall_i,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [rrss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [rrss_pkg::TIME_W-1:0]         cfg_data_i
);

  import rrss_pkg::*;

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [PID_W-1:0]   nid_q, nid_d;
  logic [TIME_W-1:0]  elapsed_q, elapsed_d;
  logic [SLICE_W-1:0] quantum_q;
  logic [TIME_W-1:0]  limit_q;
  logic               out_valid_q;
  out_word_t          res_q, res_d;
  logic               byp_q;
  entry_t             byp_data_q;

  logic               in_acc;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             head_entry;
  logic [SLICE_W-1:0] quantum;
  logic [SLICE_W-1:0] slice;
  logic               fits;
  logic [TIME_W:0]    sum;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;

  assign head_entry = byp_q ? byp_data_q : entry_t'(rd_data);
  assign quantum    = (quantum_q == '0) ? SLICE_W'(1) : quantum_q;
  assign fits       = head_entry.remaining <= BURST_W'(quantum);
  assign slice      = fits ? head_entry.remaining[SLICE_W-1:0] : quantum;
  assign sum        = {1'b0, elapsed_q} + (TIME_W + 1)'(slice);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    nid_d     = nid_q;
    elapsed_d = elapsed_q;
    wr_en     = 1'b0;
    wr_addr   = tail_q;
    wr_data   = head_entry;
    res_d     = res_q;
    if (in_acc) begin
      res_d.process_id    = '0;
      res_d.slice_time    = '0;
      res_d.retired       = 1'b0;
      res_d.limit_reached = 1'b0;
      case (in_word_i.command)
        CMD_ADD: begin
          if (count_q == CNT_FULL) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.status     = ST_ADDED;
            res_d.process_id = nid_q;
            wr_en            = 1'b1;
            wr_data.pid      = nid_q;
            wr_data.remaining = in_word_i.burst_time;
            tail_d           = ring_next(tail_q);
            count_d          = count_q + CNT_W'(1);
            nid_d            = nid_q + PID_W'(1);
          end
        end
        CMD_DISPATCH: begin
          if (count_q == '0) begin
            res_d.status = ST_EMPTY;
          end else begin
            res_d.status     = ST_DISPATCHED;
            res_d.process_id = head_entry.pid;
            res_d.slice_time = slice;
            res_d.retired    = fits;
            head_d           = ring_next(head_q);
            if (fits) begin
              count_d = count_q - CNT_W'(1);
            end else begin
              wr_en             = 1'b1;
              wr_data.pid       = head_entry.pid;
              wr_data.remaining = head_entry.remaining - BURST_W'(quantum);
              tail_d            = ring_next(tail_q);
            end
            elapsed_d = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
          end
        end
        default: begin
          res_d.status = ST_EMPTY;
        end
      endcase
      res_d.finish_time = elapsed_d;
    end
  end

  rrss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (head_d),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      nid_q       <= PID_FIRST;
      elapsed_q   <= '0;
      quantum_q   <= QUANTUM_RESET;
      limit_q     <= LIMIT_RESET;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      nid_q     <= nid_d;
      elapsed_q <= elapsed_d;
      byp_q     <= wr_en && (wr_addr == head_d);
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_QUANTUM: quantum_q <= cfg_data_i[SLICE_W-1:0];
          CFG_LIMIT:   limit_q   <= cfg_data_i;
          default:     limit_q   <= limit_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    byp_data_q <= wr_data;
  end

  always_comb begin
    out_word_o               = res_q;
    out_word_o.limit_reached = res_q.finish_time >= limit_q;
  end
  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_FULL)
    else $error("ring count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNT_FULL) |-> head_q == tail_q)
    else $error("head and tail out of step with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.command == CMD_ADD && count_q != CNT_FULL
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("add did not grow the ring");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_word_i.command == CMD_DISPATCH && count_q == '0
    |=> out_valid_o && out_word_o.status == ST_EMPTY)
    else $error("empty dispatch not reported");

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_q)
    else $error("stall without a pending result");

endmodule

`default_nettype wire
